### sv/uvbg_pkg.sv
package uvbg_pkg;

	localparam int TIME_W     = 60;
	localparam int NODE_W     = 48;
	localparam int SEQ_W      = 14;
	localparam int SECS_W     = 34;
	localparam int FRAC_W     = 32;
	localparam int COUNT_W    = 12;
	localparam int SECS_HALF  = 17;
	localparam int TICKS_W    = 24;
	localparam int PROD_W     = TICKS_W + FRAC_W;

	localparam int MAX_BATCH_DEF = 64;

	// 100 ns ticks between 1582-10-15 and 1970-01-01.
	localparam logic [TIME_W-1:0]  GREG_OFFSET   = 60'h01B21DD213814000;
	localparam logic [TICKS_W-1:0] TICKS_PER_SEC = 24'd10000000;
	localparam logic [3:0]         UUID_VERSION  = 4'h1;
	localparam logic [15:0]        VARIANT_BITS  = 16'h8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MFRAC,
		ST_MSLO,
		ST_MSHI,
		ST_ACC,
		ST_PICK,
		ST_EMIT,
		ST_BAD
	} state_t;

	typedef enum logic [1:0] {
		MSEL_FRAC,
		MSEL_SLO,
		MSEL_SHI
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_INIT,
		ACC_ADD,
		ACC_ADD_SH
	} acc_op_t;

	typedef struct packed {
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
	} tu_ctl_t;

endpackage

### sv/uvbg_time_unit.sv
// Shared multiply-accumulate unit that builds the 60-bit timestamp over
// several steps: one 24 x 32 multiply per cycle, registered, then added in.
module uvbg_time_unit (
	input  logic                            clk,
	input  uvbg_pkg::tu_ctl_t               ctl,
	input  logic [uvbg_pkg::SECS_W-1:0]     secs,
	input  logic [uvbg_pkg::FRAC_W-1:0]     frac,
	output logic [uvbg_pkg::TIME_W-1:0]     acc
);

	logic [uvbg_pkg::FRAC_W-1:0] mul_op;
	logic [uvbg_pkg::PROD_W-1:0] prod_q;
	logic [uvbg_pkg::TIME_W-1:0] acc_q;
	logic [uvbg_pkg::PROD_W+uvbg_pkg::SECS_HALF-1:0] prod_sh;

	always_comb begin
		case (ctl.mul_sel)
			uvbg_pkg::MSEL_FRAC: mul_op = frac;
			uvbg_pkg::MSEL_SLO:  mul_op = uvbg_pkg::FRAC_W'(secs[uvbg_pkg::SECS_HALF-1:0]);
			uvbg_pkg::MSEL_SHI:  mul_op = uvbg_pkg::FRAC_W'(secs[uvbg_pkg::SECS_W-1:uvbg_pkg::SECS_HALF]);
			default:             mul_op = '0;
		endcase
	end

	assign prod_sh = {prod_q, {uvbg_pkg::SECS_HALF{1'b0}}};

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= uvbg_pkg::PROD_W'(uvbg_pkg::TICKS_PER_SEC) * uvbg_pkg::PROD_W'(mul_op);
		end
		case (ctl.acc_op)
			uvbg_pkg::ACC_INIT:   acc_q <= uvbg_pkg::GREG_OFFSET +
				uvbg_pkg::TIME_W'(prod_q[uvbg_pkg::PROD_W-1:uvbg_pkg::FRAC_W]);
			uvbg_pkg::ACC_ADD:    acc_q <= acc_q + uvbg_pkg::TIME_W'(prod_q);
			uvbg_pkg::ACC_ADD_SH: acc_q <= acc_q + prod_sh[uvbg_pkg::TIME_W-1:0];
			default:              acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

### sv/uuid_v1_batch_generator_unit.sv
// Version-1 UUID batch generator.
// A request on the input channel (in_valid/in_ready) carries Unix seconds, a
// 32-bit binary fraction, a node address, a random value and a batch count.
// The block turns the time into a 60-bit count of 100 ns ticks since 1582,
// picks the clock sequence from the saved time, node and sequence, and then
// hands out one UUID per cycle, unless stalled, on the output channel
// (out_valid/out_ready), with consecutive timestamps and last_of_batch set on
// the final one. The timestamp is built by one shared multiply-accumulate
// unit in four steps, followed by a pick step for the clock sequence choice.
// A request with a count of zero or above MAX_BATCH gives a single error
// result instead, in the cycle after it is accepted.
// The block takes one request at a time: in_ready is high only when idle.
// When the receiver stalls, the current UUID holds on the outputs and the
// batch simply waits. Reset clears the saved time, node and sequence to
// zero, so the first request always seeds the sequence from random_seq.
module uuid_v1_batch_generator_unit #(
	parameter int MAX_BATCH = uvbg_pkg::MAX_BATCH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [uvbg_pkg::SECS_W-1:0]     seconds,
	input  logic [uvbg_pkg::FRAC_W-1:0]     fraction_hi,
	input  logic [uvbg_pkg::NODE_W-1:0]     node_addr,
	input  logic [uvbg_pkg::SEQ_W-1:0]      random_seq,
	input  logic [uvbg_pkg::COUNT_W-1:0]    batch_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [31:0]                     stamp_low,
	output logic [15:0]                     stamp_mid,
	output logic [15:0]                     time_hi_version,
	output logic [15:0]                     clock_seq_variant,
	output logic [uvbg_pkg::NODE_W-1:0]     node_out,
	output logic                            bad_count,
	output logic                            last_of_batch
);

	localparam int IdxW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

	uvbg_pkg::state_t  state_q, state_d;
	uvbg_pkg::tu_ctl_t tu_ctl;

	// Request fields held for the duration of the batch.
	logic [uvbg_pkg::SECS_W-1:0] secs_q;
	logic [uvbg_pkg::FRAC_W-1:0] frac_q;
	logic [uvbg_pkg::NODE_W-1:0] node_q;
	logic [uvbg_pkg::SEQ_W-1:0]  rnd_q;
	logic [IdxW-1:0]             rem_q;

	// Saved generator state.
	logic [uvbg_pkg::TIME_W-1:0] prev_time_q;
	logic [uvbg_pkg::NODE_W-1:0] prev_node_q;
	logic [uvbg_pkg::SEQ_W-1:0]  prev_seq_q;

	logic [uvbg_pkg::TIME_W-1:0] time_q;
	logic [uvbg_pkg::TIME_W-1:0] ts;
	logic [uvbg_pkg::SEQ_W-1:0]  seq_pick;

	logic in_fire, out_fire, count_bad, emit;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign count_bad = (batch_count == '0) ||
		(batch_count > uvbg_pkg::COUNT_W'(MAX_BATCH));

	uvbg_time_unit u_time (
		.clk  (clk),
		.ctl  (tu_ctl),
		.secs (secs_q),
		.frac (frac_q),
		.acc  (ts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uvbg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: steps the shared unit, then walks through the batch.
	always_comb begin
		state_d = state_q;
		tu_ctl  = '{mul_en: 1'b0, mul_sel: uvbg_pkg::MSEL_FRAC, acc_op: uvbg_pkg::ACC_HOLD};
		case (state_q)
			uvbg_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = count_bad ? uvbg_pkg::ST_BAD : uvbg_pkg::ST_MFRAC;
				end
			end
			uvbg_pkg::ST_MFRAC: begin
				tu_ctl.mul_en  = 1'b1;
				tu_ctl.mul_sel = uvbg_pkg::MSEL_FRAC;
				state_d = uvbg_pkg::ST_MSLO;
			end
			uvbg_pkg::ST_MSLO: begin
				tu_ctl.mul_en  = 1'b1;
				tu_ctl.mul_sel = uvbg_pkg::MSEL_SLO;
				tu_ctl.acc_op  = uvbg_pkg::ACC_INIT;
				state_d = uvbg_pkg::ST_MSHI;
			end
			uvbg_pkg::ST_MSHI: begin
				tu_ctl.mul_en  = 1'b1;
				tu_ctl.mul_sel = uvbg_pkg::MSEL_SHI;
				tu_ctl.acc_op  = uvbg_pkg::ACC_ADD;
				state_d = uvbg_pkg::ST_ACC;
			end
			uvbg_pkg::ST_ACC: begin
				tu_ctl.acc_op = uvbg_pkg::ACC_ADD_SH;
				state_d = uvbg_pkg::ST_PICK;
			end
			uvbg_pkg::ST_PICK: begin
				state_d = uvbg_pkg::ST_EMIT;
			end
			uvbg_pkg::ST_EMIT: begin
				if (out_fire && rem_q == '0) begin
					state_d = uvbg_pkg::ST_IDLE;
				end
			end
			uvbg_pkg::ST_BAD: begin
				if (out_fire) begin
					state_d = uvbg_pkg::ST_IDLE;
				end
			end
			default: state_d = uvbg_pkg::ST_IDLE;
		endcase
	end

	// Clock sequence: reseed on first use or a new node, bump it when time
	// has not moved forward, otherwise keep it.
	always_comb begin
		if (prev_time_q == '0 || prev_node_q != node_q) begin
			seq_pick = rnd_q;
		end else if (prev_time_q >= ts) begin
			seq_pick = prev_seq_q + uvbg_pkg::SEQ_W'(1);
		end else begin
			seq_pick = prev_seq_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			secs_q <= seconds;
			frac_q <= fraction_hi;
			node_q <= node_addr;
			rnd_q  <= random_seq;
			rem_q  <= IdxW'(batch_count - uvbg_pkg::COUNT_W'(1));
		end else if (state_q == uvbg_pkg::ST_EMIT && out_fire) begin
			rem_q <= rem_q - IdxW'(1);
		end
		if (state_q == uvbg_pkg::ST_PICK) begin
			time_q <= ts;
		end else if (state_q == uvbg_pkg::ST_EMIT && out_fire) begin
			time_q <= time_q + uvbg_pkg::TIME_W'(1);
		end
	end

	// Saved state changes only once a good request reaches its pick step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			prev_node_q <= '0;
			prev_seq_q  <= '0;
		end else if (state_q == uvbg_pkg::ST_PICK) begin
			prev_time_q <= ts + uvbg_pkg::TIME_W'(rem_q);
			prev_node_q <= node_q;
			prev_seq_q  <= seq_pick;
		end
	end

	assign emit     = (state_q == uvbg_pkg::ST_EMIT);
	assign in_ready = (state_q == uvbg_pkg::ST_IDLE);
	assign out_valid = emit || (state_q == uvbg_pkg::ST_BAD);

	// After the pick step the saved node and sequence are this batch's own,
	// so they feed the outputs directly. An error result shows all zeros.
	assign stamp_low         = emit ? time_q[31:0] : '0;
	assign stamp_mid         = emit ? time_q[47:32] : '0;
	assign time_hi_version   = emit ? {uvbg_pkg::UUID_VERSION, time_q[59:48]} : '0;
	assign clock_seq_variant = emit ? (uvbg_pkg::VARIANT_BITS | 16'(prev_seq_q)) : '0;
	assign node_out          = emit ? prev_node_q : '0;
	assign bad_count         = (state_q == uvbg_pkg::ST_BAD);
	assign last_of_batch     = bad_count || (emit && rem_q == '0);

endmodule

### sv/uvbg_checker.sv
module uvbg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] stamp_low,
	input logic [15:0] time_hi_version,
	input logic [15:0] clock_seq_variant,
	input logic [47:0] node_out,
	input logic        bad_count,
	input logic        last_of_batch
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stamp_low) && $stable(node_out))
		else $error("result changed while stalled");

	// The block never offers results while it can take a new request.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("result shown while idle");

	// An accepted request keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting a request");

	// An error result is single and carries no UUID.
	a_bad_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_count |-> last_of_batch && stamp_low == '0 &&
			node_out == '0 && clock_seq_variant == '0)
		else $error("malformed error result");

	// Good results carry version 1 and the RFC variant.
	a_version: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_count |-> time_hi_version[15:12] == 4'h1 &&
			clock_seq_variant[15:14] == 2'b10)
		else $error("bad version or variant");

endmodule

bind uuid_v1_batch_generator_unit uvbg_checker u_uvbg_checker (.*);
